@@ hdl/stra_pkg.sv @@
// Shared constants for the scale-then-rational-activation unit.
`default_nettype none
package stra_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int INV_W       = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ACT_MODE  = 2'd0,
      REG_INV_SCALE = 2'd1,
      REG_CLIP_LOW  = 2'd2,
      REG_CLIP_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_SIGMOID = 1'b0,
      MODE_TANH    = 1'b1
   } act_mode_type;

   localparam logic [INV_W-1:0]      INV_SCALE_RST = 31'd65536;
   localparam logic [CSR_DATA_W-1:0] CLIP_LOW_RST  = 32'h8000_0000;
   localparam logic [CSR_DATA_W-1:0] CLIP_HIGH_RST = 32'h7FFF_FFFF;
endpackage
`default_nettype wire

@@ hdl/scale_then_rational_activation_unit.sv @@
// Top level: streaming scale, affine, clip and rational tanh/sigmoid pipeline.
//
// Usage: each element beat on the req_ channel (req_valid/req_ready) carries a
// raw value, a gain, an offset and a last-element flag. Each accepted beat yields
// exactly one rsp_ beat with the scaled value, the activation and the flag, in
// order. The csr_ port writes mode, inverse scale and clip limits; write them
// only while idle, as the block itself does not enforce this. A beat passes
// FRAC_BITS+12 register stages (28 at Q16.16) and rsp_valid rises when it
// reaches the last: eight stages of scaling, multiply, add, clip and polynomial
// terms, one restoring-division stage per quotient bit (FRAC_BITS+3 of them)
// and a final saturation stage. Throughput is one beat per cycle while the
// receiver keeps rsp_ready high. Every stage holds a valid bit and loads when
// it is empty or when the stage after it moves, so a stalled receiver fills the
// bubbles first and req_ready drops only when all stages hold data.
// Reset clears the valid bits and restores the register defaults: sigmoid mode,
// inverse scale of 1.0 at Q16.16 and clips at the full signed range.
`default_nettype none
module scale_then_rational_activation_unit #(
   parameter int DATA_WIDTH = stra_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = stra_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]         req_raw_value,
   input  wire logic signed [DATA_WIDTH-1:0]         req_gain,
   input  wire logic signed [DATA_WIDTH-1:0]         req_offset,
   input  wire logic                                 req_end_of_vector,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]              rsp_scaled_value,
   output logic signed [FRAC_BITS+2:0]               rsp_activation,
   output logic                                      rsp_end_of_vector_out,
   input  wire logic                                 csr_wr_en,
   input  wire logic [stra_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [stra_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int DW  = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int IW  = stra_pkg::INV_W;
   localparam int P1W = DW + IW;
   localparam int EW  = 2 * DW + 64;
   localparam int MW  = F + 6;
   localparam int XW  = F + 11;
   localparam int NW  = MW + XW;
   localparam int DNW = F + 14;
   localparam int QW  = F + 3;
   localparam int AW  = F + 3;
   localparam int DIV0 = 8;
   localparam int NST = DIV0 + QW + 1;
   localparam int LST = NST - 1;

   localparam logic [P1W-F-1:0] HALF_EXT  = (P1W-F)'(1) << (DW - 1);
   localparam logic [DW-1:0]    HALF      = DW'(1) << (DW - 1);
   localparam logic [EW-1:0]    LIM62     = EW'(1) << 62;
   localparam logic [63:0]      CAP       = 64'(32) << F;
   localparam logic [XW-1:0]    K27       = XW'(27) << F;
   localparam logic [QW-1:0]    TOP       = QW'(2) << F;
   localparam logic signed [AW-1:0] ONE   = AW'(1) << F;

   // Configuration registers.
   logic                          mode_ff;
   logic [IW-1:0]                 inv_ff;
   logic [stra_pkg::CSR_DATA_W-1:0] clo_ff, chi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stra_pkg::MODE_SIGMOID;
         inv_ff  <= stra_pkg::INV_SCALE_RST;
         clo_ff  <= stra_pkg::CLIP_LOW_RST;
         chi_ff  <= stra_pkg::CLIP_HIGH_RST;
      end else if (csr_wr_en) begin
         unique case (stra_pkg::csr_index_type'(csr_index))
            stra_pkg::REG_ACT_MODE:  mode_ff <= csr_wdata[0];
            stra_pkg::REG_INV_SCALE: inv_ff  <= csr_wdata[IW-1:0];
            stra_pkg::REG_CLIP_LOW:  clo_ff  <= csr_wdata;
            stra_pkg::REG_CLIP_HIGH: chi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline control: a stage loads when empty or when its successor moves.
   logic [NST-1:0] v_ff;
   logic [NST-1:0] ce;

   always_comb begin
      ce[LST] = rsp_ready | ~v_ff[LST];
      for (int k = LST - 1; k >= 0; k--) begin
         ce[k] = ~v_ff[k] | ce[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ce[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (ce[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_ready = ce[0];

   // Flag travels with every stage.
   logic eov_ff [NST];
   always_ff @(posedge clock) begin
      if (ce[0]) begin
         eov_ff[0] <= req_end_of_vector;
      end
      for (int k = 1; k < NST; k++) begin
         if (ce[k]) begin
            eov_ff[k] <= eov_ff[k-1];
         end
      end
   end

   // Stage 0: magnitude of raw times inverse scale.
   logic [P1W-1:0]        p1_ff, p1_in;
   logic                  rneg_ff;
   logic signed [DW-1:0]  g0_ff, g1_ff, o0_ff, o1_ff, o2_ff;
   logic [DW-1:0]         rmag;

   always_comb begin
      rmag  = req_raw_value[DW-1] ? DW'(-req_raw_value) : DW'(req_raw_value);
      p1_in = P1W'(rmag) * P1W'(inv_ff);
   end

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         p1_ff   <= p1_in;
         rneg_ff <= req_raw_value[DW-1];
         g0_ff   <= req_gain;
         o0_ff   <= req_offset;
      end
      if (ce[1]) begin
         g1_ff <= g0_ff;
         o1_ff <= o0_ff;
      end
      if (ce[2]) begin
         o2_ff <= o1_ff;
      end
   end

   // Stage 1: shift and saturate to the data range.
   logic signed [DW-1:0] scl_ff [1:LST];
   logic [P1W-F-1:0]     sh1;
   logic [DW-1:0]        m1;
   logic signed [DW-1:0] scl_in;

   always_comb begin
      sh1 = p1_ff[P1W-1:F];
      m1  = (sh1 > HALF_EXT) ? HALF : sh1[DW-1:0];
      if (rneg_ff) begin
         scl_in = -$signed(m1);
      end else begin
         scl_in = (m1 == HALF) ? $signed(HALF - DW'(1)) : $signed(m1);
      end
   end

   always_ff @(posedge clock) begin
      if (ce[1]) begin
         scl_ff[1] <= scl_in;
      end
      for (int k = 2; k < NST; k++) begin
         if (ce[k]) begin
            scl_ff[k] <= scl_ff[k-1];
         end
      end
   end

   // Stage 2: gain magnitude times scaled magnitude.
   logic [2*DW-1:0] p2_ff, p2_in;
   logic            n2_ff;
   logic [DW-1:0]   gmag, smag;

   always_comb begin
      gmag  = g1_ff[DW-1] ? DW'(-g1_ff) : DW'(g1_ff);
      smag  = scl_ff[1][DW-1] ? DW'(-scl_ff[1]) : DW'(scl_ff[1]);
      p2_in = (2*DW)'(gmag) * (2*DW)'(smag);
   end

   always_ff @(posedge clock) begin
      if (ce[2]) begin
         p2_ff <= p2_in;
         n2_ff <= g1_ff[DW-1] ^ scl_ff[1][DW-1];
      end
   end

   // Stage 3: shift, saturate at 2^62, apply sign and add the offset.
   logic [EW-1:0]       wide3;
   logic [62:0]         m3;
   logic signed [63:0]  y3_ff, y3_in;

   always_comb begin
      wide3 = EW'(p2_ff) >> F;
      m3    = (wide3 > LIM62) ? 63'(LIM62) : wide3[62:0];
      y3_in = (n2_ff ? -$signed({1'b0, m3}) : $signed({1'b0, m3})) + 64'(o2_ff);
   end

   always_ff @(posedge clock) begin
      if (ce[3]) begin
         y3_ff <= y3_in;
      end
   end

   // Stage 4: clip; the high limit wins when the limits cross.
   logic signed [63:0] y4_ff, y4_in, clo, chi;

   always_comb begin
      clo   = 64'($signed(clo_ff));
      chi   = 64'($signed(chi_ff));
      y4_in = (y3_ff < clo) ? clo : y3_ff;
      if (y4_in > chi) begin
         y4_in = chi;
      end
   end

   always_ff @(posedge clock) begin
      if (ce[4]) begin
         y4_ff <= y4_in;
      end
   end

   // Stage 5: argument magnitude, halved for sigmoid, clamped to 32.0.
   logic [MW-1:0] mg5_ff, mg5_in;
   logic          ng5_ff;
   logic [63:0]   ym, am;

   always_comb begin
      ym = y4_ff[63] ? 64'(-y4_ff) : 64'(y4_ff);
      am = (mode_ff == stra_pkg::MODE_TANH) ? ym : (ym >> 1);
      mg5_in = (am > CAP) ? MW'(CAP) : am[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ce[5]) begin
         mg5_ff <= mg5_in;
         ng5_ff <= y4_ff[63];
      end
   end

   // Stage 6: square of the argument.
   logic [XW-1:0]   x2_ff;
   logic [MW-1:0]   mg6_ff;
   logic            ng6_ff;
   logic [2*MW-1:0] sq6;

   always_comb begin
      sq6 = (2*MW)'(mg5_ff) * (2*MW)'(mg5_ff);
   end

   always_ff @(posedge clock) begin
      if (ce[6]) begin
         x2_ff  <= sq6[F+XW-1:F];
         mg6_ff <= mg5_ff;
         ng6_ff <= ng5_ff;
      end
   end

   // Stage 7: numerator and denominator of the rational function.
   logic [NW-1:0]  num7_ff, num7_in;
   logic [DNW-1:0] den7_ff, den7_in;
   logic           ng7_ff;

   always_comb begin
      num7_in = NW'(mg6_ff) * NW'(K27 + x2_ff);
      den7_in = DNW'(K27) + DNW'(x2_ff) * DNW'(9);
   end

   always_ff @(posedge clock) begin
      if (ce[7]) begin
         num7_ff <= num7_in;
         den7_ff <= den7_in;
         ng7_ff  <= ng6_ff;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   logic [NW-1:0]  dr_ff [QW];
   logic [QW-1:0]  dq_ff [QW];
   logic [DNW-1:0] dd_ff [QW];
   logic           dn_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int BI = QW - 1 - j;
      logic [NW-1:0]  r_prev, trial;
      logic [QW-1:0]  q_prev, q_in;
      logic [DNW-1:0] d_prev;
      logic           n_prev, ge;

      if (j == 0) begin : g_first
         assign r_prev = num7_ff;
         assign q_prev = '0;
         assign d_prev = den7_ff;
         assign n_prev = ng7_ff;
      end else begin : g_next
         assign r_prev = dr_ff[j-1];
         assign q_prev = dq_ff[j-1];
         assign d_prev = dd_ff[j-1];
         assign n_prev = dn_ff[j-1];
      end

      always_comb begin
         trial    = NW'(d_prev) << BI;
         ge       = (r_prev >= trial);
         q_in     = q_prev;
         q_in[BI] = ge;
      end

      always_ff @(posedge clock) begin
         if (ce[DIV0+j]) begin
            dr_ff[j] <= ge ? (r_prev - trial) : r_prev;
            dq_ff[j] <= q_in;
            dd_ff[j] <= d_prev;
            dn_ff[j] <= n_prev;
         end
      end
   end

   // Final stage: saturate to 2.0, sign, and map to sigmoid if selected.
   logic signed [AW-1:0] act_ff, act_in, t_val, s_val;
   logic [QW-1:0]        qs;

   always_comb begin
      qs    = (dq_ff[QW-1] > TOP) ? TOP : dq_ff[QW-1];
      t_val = dn_ff[QW-1] ? -$signed(AW'(qs)) : $signed(AW'(qs));
      s_val = ONE + t_val;
      act_in = (mode_ff == stra_pkg::MODE_TANH) ? t_val : (s_val >>> 1);
   end

   always_ff @(posedge clock) begin
      if (ce[LST]) begin
         act_ff <= act_in;
      end
   end

   assign rsp_valid             = v_ff[LST];
   assign rsp_scaled_value      = scl_ff[LST];
   assign rsp_activation        = act_ff;
   assign rsp_end_of_vector_out = eov_ff[LST];

   // An empty pipeline always takes a beat.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (v_ff == '0) |-> req_ready)
      else $error("pipeline empty but not ready");

   // A result held by a stalled receiver stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_activation)
                                     && $stable(rsp_scaled_value)))
      else $error("stalled result changed");

   // The activation never exceeds plus or minus 2.0.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((act_ff <= $signed(AW'(TOP))) && (act_ff >= -$signed(AW'(TOP)))))
      else $error("activation out of range");

   // The final division remainder is always below the divisor.
   a_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[LST-1] |-> (dr_ff[QW-1] < NW'(dd_ff[QW-1])))
      else $error("division remainder not below divisor");
endmodule
`default_nettype wire
